// ===== hw/rtl/archive_directory_parser_unit_macros.svh =====
// Assertion helpers shared by the RTL of the directory parser.
`ifndef ARCHIVE_DIRECTORY_PARSER_UNIT_MACROS_SVH
`define ARCHIVE_DIRECTORY_PARSER_UNIT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ADPU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define ADPU_ASSERT(lbl, prop, msg) \
    `ADPU_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/adpu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adpu_pkg;

    // Header layout and limits.
    localparam logic [15:0] C_PAD_POS      = 16'd10;
    localparam logic [15:0] C_MIN_DIR      = 16'd12;
    localparam logic [7:0]  C_MAX_NAME_LEN = 8'd255;
    localparam logic [32:0] C_SIZE_CAP     = 33'h1_0000_0000;

    // Expected signature bytes at the archive start.
    localparam logic [7:0] C_MAGIC [4] = '{8'h52, 8'h4E, 8'h43, 8'h41};

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_NAME   = 3'd2,
        PH_OFFSET = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_DIR   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_MAGIC     = 4'd1,
        ERR_SIZE_COPY = 4'd2,
        ERR_PAD       = 4'd3,
        ERR_TOO_SMALL = 4'd4,
        ERR_PAST_END  = 4'd5,
        ERR_CROSS     = 4'd6,
        ERR_NAME_LONG = 4'd7,
        ERR_OFF_RANGE = 4'd8,
        ERR_ORDER     = 4'd9,
        ERR_TERM      = 4'd10
    } t_err;

    // One result as it travels from the walker to the output register.
    typedef struct packed {
        t_kind       kind;
        logic [13:0] index;
        logic [31:0] offset;
        logic [7:0]  nlen;
        t_err        code;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/adpu_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "archive_directory_parser_unit_macros.svh"

module adpu_walker
    import adpu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_restart,
    input  wire logic [32:0] i_arch_size,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_dlen, n_dlen;
    logic [7:0]  r_nc, n_nc;
    logic [31:0] r_sh, n_sh;
    logic [1:0]  r_obs, n_obs;
    logic [31:0] r_prev, n_prev;
    logic [13:0] r_ent, n_ent;

    t_phase      w_ph;
    logic [15:0] w_pos, w_dlen;
    logic [7:0]  w_nc;
    logic [31:0] w_sh, w_prev, w_off;
    logic [1:0]  w_obs;
    logic [13:0] w_ent;
    logic        w_act, w_last, w_cross;
    t_err        w_err;
    logic        w_dir_ok, w_entry_ok;

    // A restart byte sees a cleared walk in the header phase.
    assign w_ph   = i_restart ? PH_HEADER : r_phase;
    assign w_pos  = i_restart ? 16'd0 : r_pos;
    assign w_dlen = i_restart ? 16'd0 : r_dlen;
    assign w_nc   = i_restart ? 8'd0 : r_nc;
    assign w_sh   = i_restart ? 32'd0 : r_sh;
    assign w_obs  = i_restart ? 2'd0 : r_obs;
    assign w_prev = i_restart ? 32'd0 : r_prev;
    assign w_ent  = i_restart ? 14'd0 : r_ent;

    assign w_act   = i_en && (i_restart || (r_phase != PH_IDLE && r_phase != PH_DONE));
    assign w_last  = ({1'b0, w_pos} + 17'd1) == {1'b0, w_dlen};
    assign w_cross = ({1'b0, w_pos} + 17'd5) > {1'b0, w_dlen};
    assign w_off   = {w_sh[23:0], i_data};

    // Checks in stream order; the first violation wins.
    always_comb begin
        w_err      = ERR_NONE;
        w_dir_ok   = 1'b0;
        w_entry_ok = 1'b0;
        unique case (w_ph)
            PH_HEADER: begin
                if (w_pos < 16'd4) begin
                    if (i_data != C_MAGIC[w_pos[1:0]]) w_err = ERR_MAGIC;
                end else if (w_pos == 16'd9) begin
                    if ({w_sh[7:0], i_data} != w_dlen) w_err = ERR_SIZE_COPY;
                end else if (w_pos == C_PAD_POS) begin
                    if (i_data != 8'd0)                     w_err = ERR_PAD;
                    else if (w_dlen < C_MIN_DIR)            w_err = ERR_TOO_SMALL;
                    else if ({17'd0, w_dlen} >= i_arch_size) w_err = ERR_PAST_END;
                end
            end
            PH_NAME: begin
                if (i_data == 8'd0) begin
                    if (w_nc == 8'd0) begin
                        if (w_last && w_ent != 14'd0) w_dir_ok = 1'b1;
                        else                          w_err = ERR_TERM;
                    end else if (w_cross) begin
                        w_err = ERR_CROSS;
                    end
                end else if (w_last) begin
                    w_err = ERR_CROSS;
                end else if (w_nc >= C_MAX_NAME_LEN) begin
                    w_err = ERR_NAME_LONG;
                end
            end
            PH_OFFSET: begin
                if (w_obs == 2'd3) begin
                    if (w_off < {16'd0, w_dlen} || {1'b0, w_off} >= i_arch_size) begin
                        w_err = ERR_OFF_RANGE;
                    end else if ((w_ent == 14'd0) ? (w_off != {16'd0, w_dlen})
                                                  : (w_off <= w_prev)) begin
                        w_err = ERR_ORDER;
                    end else if (w_last) begin
                        w_err = ERR_TERM;
                    end else begin
                        w_entry_ok = 1'b1;
                    end
                end
            end
            default: begin
                w_err = ERR_NONE;
            end
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_act) begin
            if (w_err != ERR_NONE || w_dir_ok) begin
                n_phase = PH_DONE;
            end else begin
                unique case (w_ph)
                    PH_HEADER: n_phase = (w_pos == C_PAD_POS) ? PH_NAME : PH_HEADER;
                    PH_NAME:   n_phase = (i_data == 8'd0) ? PH_OFFSET : PH_NAME;
                    PH_OFFSET: n_phase = (w_obs == 2'd3) ? PH_NAME : PH_OFFSET;
                    default:   n_phase = PH_DONE;
                endcase
            end
        end
    end

    // Walk counters and shift register. After a failure they no longer matter.
    always_comb begin
        n_pos  = r_pos;
        n_dlen = r_dlen;
        n_nc   = r_nc;
        n_sh   = r_sh;
        n_obs  = r_obs;
        n_prev = r_prev;
        n_ent  = r_ent;
        if (w_act) begin
            n_pos  = w_pos + 16'd1;
            n_dlen = w_dlen;
            n_nc   = w_nc;
            n_sh   = w_sh;
            n_obs  = w_obs;
            n_prev = w_prev;
            n_ent  = w_ent;
            unique case (w_ph)
                PH_HEADER: begin
                    if (w_pos == 16'd4)      n_dlen = {i_data, 8'd0};
                    else if (w_pos == 16'd5) n_dlen = {w_dlen[15:8], i_data};
                    else if (w_pos == 16'd8) n_sh = {24'd0, i_data};
                    else if (w_pos == 16'd9) n_sh = {16'd0, w_sh[7:0], i_data};
                    else if (w_pos == C_PAD_POS) begin
                        n_nc = 8'd0;
                        n_sh = 32'd0;
                    end
                end
                PH_NAME: begin
                    if (i_data == 8'd0) begin
                        n_obs = 2'd0;
                        n_sh  = 32'd0;
                    end else begin
                        n_nc = w_nc + 8'd1;
                    end
                end
                PH_OFFSET: begin
                    n_sh  = w_off;
                    n_obs = w_obs + 2'd1;
                    if (w_obs == 2'd3) begin
                        n_prev = w_off;
                        n_ent  = w_ent + 14'd1;
                        n_nc   = 8'd0;
                    end
                end
                default: begin
                    n_pos = w_pos + 16'd1;
                end
            endcase
        end
    end

    // Result of this byte, if it produces one.
    always_comb begin
        o_res_valid  = w_act && (w_err != ERR_NONE || w_dir_ok || w_entry_ok);
        o_res.kind   = (w_err != ERR_NONE) ? KIND_ERROR : (w_dir_ok ? KIND_DIR : KIND_ENTRY);
        o_res.index  = (w_dir_ok || w_entry_ok) ? w_ent : 14'd0;
        o_res.offset = w_entry_ok ? w_off : 32'd0;
        o_res.nlen   = w_entry_ok ? w_nc : 8'd0;
        o_res.code   = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 16'd0;
            r_dlen  <= 16'd0;
            r_nc    <= 8'd0;
            r_sh    <= 32'd0;
            r_obs   <= 2'd0;
            r_prev  <= 32'd0;
            r_ent   <= 14'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_dlen  <= n_dlen;
            r_nc    <= n_nc;
            r_sh    <= n_sh;
            r_obs   <= n_obs;
            r_prev  <= n_prev;
            r_ent   <= n_ent;
        end
    end

    // Entering the finished phase always reports something.
    `ADPU_ASSERT(a_done_reports, w_act && n_phase == PH_DONE |-> o_res_valid, "silent finish")
    // A reported entry lies at or beyond the directory end.
    `ADPU_ASSERT(a_entry_in_range,
                 o_res_valid && o_res.kind == KIND_ENTRY |-> w_off >= {16'd0, w_dlen},
                 "entry offset below directory end")
    // An accepted directory has at least one entry.
    `ADPU_ASSERT(a_dir_nonempty,
                 o_res_valid && o_res.kind == KIND_DIR |-> o_res.index != 14'd0,
                 "empty directory accepted")

endmodule

`default_nettype wire

// ===== hw/rtl/archive_directory_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "archive_directory_parser_unit_macros.svh"

// Archive directory parser. Takes one archive byte per request and accepts a
// new request every clock cycle, sustained, as long as results are taken. A
// byte enters an input register, is checked in one pass against the walk
// state (the widest logic is the 33-bit compare of an offset against the
// archive size, beside the 32-bit compare against the previous offset), and
// any result lands in the output register when the byte leaves the input
// register. The output register keeps a held result while the next byte is
// already waiting in the input register. Write the size register only while
// the unit is idle; values above 2^32 saturate.
module archive_directory_parser_unit
    import adpu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [32:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [13:0]      o_entry_index,
    output logic [31:0]      o_entry_offset,
    output logic [7:0]       o_name_length,
    output logic [3:0]       o_error_code
);

    logic [32:0] r_arch;
    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_restart;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_adv, w_in_acc;
    logic        w_res_valid;
    t_result     w_res;

    // The walker step runs whenever the output slot is free or being emptied.
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Archive size register with saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch <= 33'd0;
        end else if (i_cfg_we) begin
            r_arch <= i_cfg_data[32] ? C_SIZE_CAP : i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_data    <= i_data_byte;
            r_in_restart <= i_restart;
        end
    end

    adpu_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_data      (r_in_data),
        .i_restart   (r_in_restart),
        .i_arch_size (r_arch),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_entry_index  = r_out.index;
    assign o_entry_offset = r_out.offset;
    assign o_name_length  = r_out.nlen;
    assign o_error_code   = r_out.code;

    // A waiting byte is never dropped.
    `ADPU_ASSERT(a_in_kept, r_in_valid && !w_adv |=> r_in_valid, "input request lost")
    // Error results carry a code and nothing else.
    `ADPU_ASSERT(a_err_fields,
                 o_out_valid && o_kind == KIND_ERROR |->
                     o_error_code != ERR_NONE && o_entry_index == 14'd0,
                 "bad error result")
    // Non-error results carry no code.
    `ADPU_ASSERT(a_ok_fields,
                 o_out_valid && o_kind != KIND_ERROR |-> o_error_code == ERR_NONE,
                 "code on good result")

endmodule

`default_nettype wire
